FILE: src/bscu_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bscu_pkg;

  // Default number of fractional bits on the pressure result
  localparam int PRESS_FRAC_DEF = 8;

  // Configuration port
  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    REG_TEMP  = 2'd0,
    REG_PLOW  = 2'd1,
    REG_PHIGH = 2'd2,
    REG_P9    = 2'd3
  } cfg_reg_t;

  // Temperature limits in 0.01 degC
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;

  // Pressure saturation limit
  localparam logic [24:0] PRESS_MAX = '1;

  // Fine temperature offset and the constant bias of the divisor term
  localparam logic signed [24:0] FINE_OFFSET = 25'sd128000;
  localparam logic [63:0] DIV_BIAS = 64'h0000_8000_0000_0000;
  localparam logic [20:0] PR_BASE = 21'h10_0000;
  localparam logic [11:0] NUM_SCALE = 12'd3125;

  // Divider: 64 quotient bits, a few per stage
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = 64 / DIV_STEP;

  // Unpacked calibration coefficients
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        c1;
    logic signed [15:0] c2;
    logic signed [15:0] c3;
    logic signed [15:0] c4;
    logic signed [15:0] c5;
    logic signed [15:0] c6;
    logic signed [15:0] c7;
    logic signed [15:0] c8;
    logic signed [15:0] c9;
  } coef_t;

  // Per-item data that rides along the divider
  typedef struct packed {
    logic signed [14:0] tc;
    logic               neg;
    logic               ok;
  } side_t;

endpackage

FILE: src/bscu_in_if.sv
// Input channel: raw pressure and temperature conversions.
interface bscu_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;

  modport source(output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

FILE: src/bscu_out_if.sv
// Output channel: compensated temperature and pressure.
interface bscu_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [24:0]        pressure_q8;
  logic               pressure_valid;

  modport source(output valid, output temperature_centi, output pressure_q8,
                 output pressure_valid, input ready);
  modport sink(input valid, input temperature_centi, input pressure_q8,
               input pressure_valid, output ready);
endinterface

FILE: src/bscu_front.sv
// Temperature polynomial and pressure numerator/divisor, eleven stages.
module bscu_front
  import bscu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  input  coef_t       coef,
  output logic        out_valid,
  output logic [63:0] num_mag,
  output logic [30:0] den_mag,
  output side_t       side
);

  logic [10:0] v;

  logic [19:0]        adp_p [1:7];
  logic signed [14:0] tc_p  [4:10];

  logic signed [17:0] s1_da;
  logic signed [16:0] s1_db;
  logic signed [22:0] s2_ta;
  logic [19:0]        s2_sq;
  logic signed [23:0] s3_fine;
  logic signed [24:0] s4_pa;
  logic [46:0]        s5_psq;
  logic signed [40:0] s5_pc5;
  logic signed [40:0] s5_pc2;
  logic [63:0]        s6_m6;
  logic [63:0]        s6_m3;
  logic signed [40:0] s6_pc5;
  logic signed [40:0] s6_pc2;
  logic [63:0]        s7_pb;
  logic [63:0]        s7_x;
  logic [63:0]        s8_diff;
  logic [47:0]        s8_plo;
  logic [31:0]        s8_phi;
  logic [43:0]        s9_nlo;
  logic [31:0]        s9_nhi;
  logic [30:0]        s9_den;
  logic [63:0]        s10_num;
  logic [30:0]        s10_den;

  logic signed [17:0] da_next;
  logic signed [16:0] db_next;
  logic signed [33:0] ta_prod;
  logic signed [33:0] sq_prod;
  logic signed [36:0] tb_prod;
  logic signed [22:0] tb;
  logic signed [23:0] fine_next;
  logic signed [27:0] t5;
  logic signed [19:0] tcw;
  logic signed [14:0] tc_next;
  logic signed [24:0] pa_next;
  logic signed [49:0] psq_prod;
  logic signed [40:0] pc5_prod;
  logic signed [40:0] pc2_prod;
  logic signed [63:0] m6_prod;
  logic signed [63:0] m3_prod;
  logic [63:0]        pb_next;
  logic [63:0]        m3sh;
  logic [63:0]        x_next;
  logic [20:0]        pr_w;
  logic [63:0]        diff_next;
  logic [47:0]        plo_next;
  logic [31:0]        phi_next;
  logic [63:0]        cprod;
  logic [43:0]        nlo_next;
  logic [31:0]        nhi_next;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[9:0], in_valid};
    end
  end

  assign out_valid = v[10];

  // Stage 1: offsets of the raw temperature
  assign da_next = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
  assign db_next = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, coef.t1});

  // Stage 2: linear and square terms
  assign ta_prod = s1_da * coef.t2;
  assign sq_prod = s1_db * s1_db;

  // Stage 3: quadratic term and fine temperature
  assign tb_prod   = $signed({1'b0, s2_sq}) * coef.t3;
  assign tb        = tb_prod[36:14];
  assign fine_next = s2_ta + tb;

  // Stage 4: temperature in 0.01 degC with saturation, pressure offset
  assign t5  = s3_fine * 28'sd5 + 28'sd128;
  assign tcw = t5[27:8];

  always_comb begin
    if (tcw < TEMP_MIN) begin
      tc_next = 15'(TEMP_MIN);
    end else if (tcw > TEMP_MAX) begin
      tc_next = 15'(TEMP_MAX);
    end else begin
      tc_next = tcw[14:0];
    end
  end

  assign pa_next = s3_fine - FINE_OFFSET;

  // Stage 5: square and linear products of the offset
  assign psq_prod = s4_pa * s4_pa;
  assign pc5_prod = s4_pa * coef.c5;
  assign pc2_prod = s4_pa * coef.c2;

  // Stage 6: second-order coefficients
  assign m6_prod = $signed({1'b0, s5_psq}) * coef.c6;
  assign m3_prod = $signed({1'b0, s5_psq}) * coef.c3;

  // Stage 7: sum the numerator offset and the divisor polynomial
  assign pb_next = s6_m6 + ({{23{s6_pc5[40]}}, s6_pc5} << 17)
                 + ({{48{coef.c4[15]}}, coef.c4} << 35);
  assign m3sh    = $signed(s6_m3) >>> 8;
  assign x_next  = m3sh + ({{23{s6_pc2[40]}}, s6_pc2} << 12) + DIV_BIAS;

  // Stage 8: numerator difference, partial products of the divisor scale
  assign pr_w      = PR_BASE - {1'b0, adp_p[7]};
  assign diff_next = {12'b0, pr_w, 31'b0} - s7_pb;
  assign plo_next  = s7_x[31:0] * coef.c1;
  assign phi_next  = 32'(s7_x[63:32] * coef.c1);

  // Stage 9: divisor, partial products of the numerator scale
  assign cprod    = {16'b0, s8_plo} + {s8_phi, 32'b0};
  assign nlo_next = s8_diff[31:0] * NUM_SCALE;
  assign nhi_next = 32'(s8_diff[63:32] * NUM_SCALE);

  // Data registers, held while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      adp_p[1] <= raw_pressure;
      for (int i = 2; i <= 7; i++) begin
        adp_p[i] <= adp_p[i-1];
      end
      tc_p[4] <= tc_next;
      for (int i = 5; i <= 10; i++) begin
        tc_p[i] <= tc_p[i-1];
      end
      s1_da   <= da_next;
      s1_db   <= db_next;
      s2_ta   <= ta_prod[33:11];
      s2_sq   <= sq_prod[31:12];
      s3_fine <= fine_next;
      s4_pa   <= pa_next;
      s5_psq  <= psq_prod[46:0];
      s5_pc5  <= pc5_prod;
      s5_pc2  <= pc2_prod;
      s6_m6   <= m6_prod;
      s6_m3   <= m3_prod;
      s6_pc5  <= s5_pc5;
      s6_pc2  <= s5_pc2;
      s7_pb   <= pb_next;
      s7_x    <= x_next;
      s8_diff <= diff_next;
      s8_plo  <= plo_next;
      s8_phi  <= phi_next;
      s9_nlo  <= nlo_next;
      s9_nhi  <= nhi_next;
      s9_den  <= cprod[63:33];
      s10_num <= {20'b0, s9_nlo} + {s9_nhi, 32'b0};
      s10_den <= s9_den;
      // Stage 11: split into sign and magnitudes for the divider
      num_mag  <= s10_num[63] ? (64'd0 - s10_num) : s10_num;
      den_mag  <= s10_den[30] ? (31'd0 - s10_den) : s10_den;
      side.tc  <= tc_p[10];
      side.neg <= s10_num[63] ^ s10_den[30];
      side.ok  <= |s10_den;
    end
  end

endmodule

FILE: src/bscu_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
module bscu_div
  import bscu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] num,
  input  logic [30:0] den,
  input  side_t       side_in,
  output logic        out_valid,
  output logic [63:0] quo,
  output side_t       side_out
);

  logic [DIV_STAGES-1:0] v;
  logic [63:0] nq  [DIV_STAGES];
  logic [30:0] rem [DIV_STAGES];
  logic [30:0] dv  [DIV_STAGES];
  side_t       sd  [DIV_STAGES];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DIV_STAGES-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [63:0] n_in;
    logic [63:0] n_out;
    logic [30:0] r_in;
    logic [30:0] r_out;
    logic [30:0] d_in;
    side_t       s_in;

    if (g == 0) begin : g_first
      assign n_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign s_in = side_in;
    end else begin : g_next
      assign n_in = nq[g-1];
      assign r_in = rem[g-1];
      assign d_in = dv[g-1];
      assign s_in = sd[g-1];
    end

    // Shift in numerator bits, subtract where the divisor fits
    always_comb begin
      logic [31:0] t;
      n_out = n_in;
      r_out = r_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        t     = {r_out, n_out[63]};
        n_out = {n_out[62:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t        = t - {1'b0, d_in};
          n_out[0] = 1'b1;
        end
        r_out = t[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g]  <= n_out;
        rem[g] <= r_out;
        dv[g]  <= d_in;
        sd[g]  <= s_in;
      end
    end
  end

  assign out_valid = v[DIV_STAGES-1];
  assign quo       = nq[DIV_STAGES-1];
  assign side_out  = sd[DIV_STAGES-1];

endmodule

FILE: src/bscu_back.sv
// Post-division correction terms, rescale and saturation, eight stages.
module bscu_back
  import bscu_pkg::*;
#(
  parameter int FRAC_BITS = PRESS_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        quo,
  input  side_t              side_in,
  input  coef_t              coef,
  output logic               out_valid,
  output logic signed [14:0] temperature_centi,
  output logic [24:0]        pressure_q8,
  output logic               pressure_valid
);

  localparam int UP = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int DN = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam logic [63:0] LIMIT = 64'(PRESS_MAX >> UP);

  logic [7:0] v;
  side_t      sd_p [1:7];

  logic [63:0]        b1_pr;
  logic [63:0]        b2_s;
  logic [63:0]        b2_pr;
  logic signed [48:0] b2_alo;
  logic [31:0]        b2_ahi;
  logic signed [48:0] b2_wlo;
  logic [31:0]        b2_whi;
  logic [63:0]        b3_a;
  logic [63:0]        b3_s;
  logic [63:0]        b3_pr;
  logic [63:0]        b3_wb;
  logic [63:0]        b4_p0;
  logic [31:0]        b4_p1;
  logic [31:0]        b4_p2;
  logic [63:0]        b4_pr;
  logic [63:0]        b4_wb;
  logic [63:0]        b5_wa;
  logic [63:0]        b5_pr;
  logic [63:0]        b5_wb;
  logic [63:0]        b6_sum;
  logic [63:0]        b7_ps;

  logic [63:0]        s_w;
  logic signed [48:0] alo_w;
  logic [31:0]        ahi_w;
  logic signed [48:0] wlo_w;
  logic [31:0]        whi_w;
  logic [63:0]        a_w;
  logic [63:0]        w_w;
  logic [63:0]        wb_w;
  logic [63:0]        prod_w;
  logic [63:0]        wa_w;
  logic [63:0]        sh_w;
  logic [63:0]        ps_next;
  logic [63:0]        pd;
  logic [24:0]        pout;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_valid};
    end
  end

  assign out_valid = v[7];

  // Stage 2: partial products of P9 times the scaled quotient and of P8
  assign s_w   = $signed(b1_pr) >>> 13;
  assign alo_w = $signed({1'b0, s_w[31:0]}) * coef.c9;
  assign ahi_w = 32'($signed(s_w[63:32]) * coef.c9);
  assign wlo_w = $signed({1'b0, b1_pr[31:0]}) * coef.c8;
  assign whi_w = 32'($signed(b1_pr[63:32]) * coef.c8);

  // Stage 3: merge partial products
  assign a_w  = {{15{b2_alo[48]}}, b2_alo} + {b2_ahi, 32'b0};
  assign w_w  = {{15{b2_wlo[48]}}, b2_wlo} + {b2_whi, 32'b0};
  assign wb_w = $signed(w_w) >>> 19;

  // Stage 5: merge the wrapped square product
  assign prod_w = b4_p0 + {b4_p1 + b4_p2, 32'b0};
  assign wa_w   = $signed(prod_w) >>> 25;

  // Stage 7: scale down and add the constant term
  assign sh_w    = $signed(b6_sum) >>> 8;
  assign ps_next = sh_w + ({{48{coef.c7[15]}}, coef.c7} << 4);

  // Stage 8: drop negatives, rescale and saturate
  assign pd = b7_ps >> DN;

  always_comb begin
    if (!sd_p[7].ok || b7_ps[63] || (b7_ps == '0)) begin
      pout = '0;
    end else if (pd > LIMIT) begin
      pout = PRESS_MAX;
    end else begin
      pout = 25'(pd << UP);
    end
  end

  // Data registers, held while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      sd_p[1] <= side_in;
      for (int i = 2; i <= 7; i++) begin
        sd_p[i] <= sd_p[i-1];
      end
      b1_pr  <= side_in.neg ? (64'd0 - quo) : quo;
      b2_s   <= s_w;
      b2_pr  <= b1_pr;
      b2_alo <= alo_w;
      b2_ahi <= ahi_w;
      b2_wlo <= wlo_w;
      b2_whi <= whi_w;
      b3_a   <= a_w;
      b3_s   <= b2_s;
      b3_pr  <= b2_pr;
      b3_wb  <= wb_w;
      b4_p0  <= b3_a[31:0] * b3_s[31:0];
      b4_p1  <= 32'(b3_a[31:0] * b3_s[63:32]);
      b4_p2  <= 32'(b3_a[63:32] * b3_s[31:0]);
      b4_pr  <= b3_pr;
      b4_wb  <= b3_wb;
      b5_wa  <= wa_w;
      b5_pr  <= b4_pr;
      b5_wb  <= b4_wb;
      b6_sum <= b5_pr + b5_wa + b5_wb;
      b7_ps  <= ps_next;
      temperature_centi <= sd_p[7].tc;
      pressure_q8       <= pout;
      pressure_valid    <= sd_p[7].ok;
    end
  end

endmodule

FILE: src/barometric_sensor_compensation_unit.sv
// Throughput: one item per cycle; the pipeline advances whenever its output
// register is empty or being taken, so a stall freezes every stage in place.
// The 64-bit divide takes 16 of the stages at four quotient bits each.
// Reset (synchronous, active high) empties the pipeline and clears the
// calibration registers to zero.
module barometric_sensor_compensation_unit
  import bscu_pkg::*;
#(
  parameter int PRESSURE_FRAC_BITS = PRESS_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bscu_in_if.sink           in_ch,
  bscu_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [47:0]        temp_coeffs;
  logic [63:0]        press_coeffs_low;
  logic [63:0]        press_coeffs_high;
  logic signed [15:0] press_coeff_nine;
  coef_t              coef;

  logic        en;
  logic        f_valid;
  logic [63:0] f_num;
  logic [30:0] f_den;
  side_t       f_side;
  logic        d_valid;
  logic [63:0] d_quo;
  side_t       d_side;
  logic        o_valid;
  logic signed [14:0] o_temp;
  logic [24:0] o_press;
  logic        o_pvalid;

  // Configuration writes
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_reg_t'(paddr[4:3]))
        REG_TEMP:  temp_coeffs       <= pwdata[47:0];
        REG_PLOW:  press_coeffs_low  <= pwdata;
        REG_PHIGH: press_coeffs_high <= pwdata;
        REG_P9:    press_coeff_nine  <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_reg_t'(paddr[4:3]))
      REG_TEMP:  prdata = {16'b0, temp_coeffs};
      REG_PLOW:  prdata = press_coeffs_low;
      REG_PHIGH: prdata = press_coeffs_high;
      REG_P9:    prdata = {48'b0, press_coeff_nine};
      default:   prdata = '0;
    endcase
  end

  // Unpack coefficients
  always_comb begin
    coef.t1 = temp_coeffs[15:0];
    coef.t2 = temp_coeffs[31:16];
    coef.t3 = temp_coeffs[47:32];
    coef.c1 = press_coeffs_low[15:0];
    coef.c2 = press_coeffs_low[31:16];
    coef.c3 = press_coeffs_low[47:32];
    coef.c4 = press_coeffs_low[63:48];
    coef.c5 = press_coeffs_high[15:0];
    coef.c6 = press_coeffs_high[31:16];
    coef.c7 = press_coeffs_high[47:32];
    coef.c8 = press_coeffs_high[63:48];
    coef.c9 = press_coeff_nine;
  end

  // Advance the whole pipeline unless a finished item is held
  assign en          = !o_valid || out_ch.ready;
  assign in_ch.ready = en;

  bscu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (in_ch.valid),
    .raw_pressure    (in_ch.raw_pressure),
    .raw_temperature (in_ch.raw_temperature),
    .coef            (coef),
    .out_valid       (f_valid),
    .num_mag         (f_num),
    .den_mag         (f_den),
    .side            (f_side)
  );

  bscu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  bscu_back #(
    .FRAC_BITS (PRESSURE_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .in_valid          (d_valid),
    .quo               (d_quo),
    .side_in           (d_side),
    .coef              (coef),
    .out_valid         (o_valid),
    .temperature_centi (o_temp),
    .pressure_q8       (o_press),
    .pressure_valid    (o_pvalid)
  );

  assign out_ch.valid             = o_valid;
  assign out_ch.temperature_centi = o_temp;
  assign out_ch.pressure_q8       = o_press;
  assign out_ch.pressure_valid    = o_pvalid;

`ifndef SYNTHESIS
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ($signed(out_ch.temperature_centi) >= TEMP_MIN) &&
                     ($signed(out_ch.temperature_centi) <= TEMP_MAX))
    else $error("temperature result outside saturation range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.pressure_valid |-> out_ch.pressure_q8 == '0)
    else $error("zero divisor item carries nonzero pressure");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the output is stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result presented right after reset");
`endif

endmodule

FILE: sim/tb_top.sv
// Testbench for the barometric compensation unit: random and directed items, self-checking.
`timescale 1ns / 1ps

module tb_top;
  import bscu_pkg::*;

  localparam int FRAC_BITS = PRESS_FRAC_DEF;
  localparam int LAT_WAIT  = 60;

  typedef struct {
    logic signed [14:0] temperature_centi;
    logic [24:0]        pressure_q8;
    logic               pressure_valid;
  } comp_result_t;

  // Compensation predictor with its own copy of the calibration registers
  class comp_scoreboard;
    logic [47:0]  temp_cal;
    logic [63:0]  plow_cal;
    logic [63:0]  phigh_cal;
    logic [15:0]  p9_cal;
    comp_result_t pending_q[$];
    int           errors;

    function new();
      temp_cal = '0; plow_cal = '0; phigh_cal = '0; p9_cal = '0; errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] val);
      case (idx)
        REG_TEMP:  temp_cal = val[47:0];
        REG_PLOW:  plow_cal = val;
        REG_PHIGH: phigh_cal = val;
        REG_P9:    p9_cal = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function logic [63:0] asr(logic [63:0] x, int n);
      return $unsigned($signed(x) >>> n);
    endfunction

    // Work out the compensated result of one accepted item
    function void note_item(logic [19:0] rp, logic [19:0] rt);
      logic [63:0] adp, adt, t1, t2, t3, c1, c2, c3, c4, c5, c6, c7, c8, c9;
      logic [63:0] da, ta, db, tb, fine, pa, pb, pr, wa, wb, un, ud, q, num, pout;
      longint tcs, ps;
      comp_result_t r;
      adp = {44'd0, rp};
      adt = {44'd0, rt};
      t1 = {48'd0, temp_cal[15:0]};
      t2 = sx16(temp_cal[31:16]);
      t3 = sx16(temp_cal[47:32]);
      c1 = {48'd0, plow_cal[15:0]};
      c2 = sx16(plow_cal[31:16]);
      c3 = sx16(plow_cal[47:32]);
      c4 = sx16(plow_cal[63:48]);
      c5 = sx16(phigh_cal[15:0]);
      c6 = sx16(phigh_cal[31:16]);
      c7 = sx16(phigh_cal[47:32]);
      c8 = sx16(phigh_cal[63:48]);
      c9 = sx16(p9_cal);
      // temperature
      da = (adt >> 3) - (t1 << 1);
      ta = asr(da * t2, 11);
      db = (adt >> 4) - t1;
      tb = asr(asr(db * db, 12) * t3, 14);
      fine = ta + tb;
      tcs = $signed(asr(fine * 64'd5 + 64'd128, 8));
      if (tcs < TEMP_MIN) tcs = TEMP_MIN;
      if (tcs > TEMP_MAX) tcs = TEMP_MAX;
      r.temperature_centi = tcs[14:0];
      // pressure
      pa = fine - 64'd128000;
      pb = pa * pa * c6;
      pb = pb + pa * c5 * 64'd131072;
      pb = pb + c4 * 64'd34359738368;
      pa = asr(pa * pa * c3, 8) + pa * c2 * 64'd4096;
      pa = asr((64'd140737488355328 + pa) * c1, 33);
      pout = '0;
      r.pressure_valid = 1'b1;
      if (pa == 64'd0) begin
        r.pressure_valid = 1'b0;
      end else begin
        pr = 64'd1048576 - adp;
        num = (pr * 64'd2147483648 - pb) * 64'd3125;
        un = num[63] ? -num : num;
        ud = pa[63] ? -pa : pa;
        q = un / ud;
        pr = (num[63] != pa[63]) ? -q : q;
        wa = asr(c9 * asr(pr, 13) * asr(pr, 13), 25);
        wb = asr(c8 * pr, 19);
        pr = asr(pr + wa + wb, 8) + c7 * 64'd16;
        ps = $signed(pr);
        if (ps > 0) begin
          pout = pr;
          if (FRAC_BITS < 8) pout = pout >> (8 - FRAC_BITS);
          if (FRAC_BITS > 8) begin
            if (pout > (64'd33554431 >> (FRAC_BITS - 8))) pout = 64'd33554431;
            else pout = pout << (FRAC_BITS - 8);
          end
          if (pout > 64'd33554431) pout = 64'd33554431;
        end
      end
      r.pressure_q8 = pout[24:0];
      pending_q.push_back(r);
    endfunction

    // Compare one result against the oldest prediction
    function void check_result(logic signed [14:0] tc, logic [24:0] pq, logic pv);
      comp_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: temperature_centi=%0d pressure_q8=%0d", tc, pq);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (tc !== e.temperature_centi) begin
        $error("temperature_centi: expected %0d, actual %0d", e.temperature_centi, tc);
        errors++;
      end
      if (pq !== e.pressure_q8) begin
        $error("pressure_q8: expected %0d, actual %0d", e.pressure_q8, pq);
        errors++;
      end
      if (pv !== e.pressure_valid) begin
        $error("pressure_valid: expected %0d, actual %0d", e.pressure_valid, pv);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  bscu_in_if  in_ch();
  bscu_out_if out_ch();

  comp_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  barometric_sensor_compensation_unit i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Write one calibration register over the config port
  task automatic cfg_write(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(logic [19:0] rp, logic [19:0] rt);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.raw_pressure = rp;
    in_ch.raw_temperature = rt;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(rp, rt);
  endtask

  // Let the pipeline drain before touching the registers
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                          logic [15:0] p9);
    cfg_write(REG_TEMP, {16'd0, tc});
    cfg_write(REG_PLOW, pl);
    cfg_write(REG_PHIGH, ph);
    cfg_write(REG_P9, {48'd0, p9});
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Take results at the rising edge
  initial begin
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.temperature_centi, out_ch.pressure_q8, out_ch.pressure_valid);
    end
  end

  initial begin
    logic [47:0] typ_t;
    logic [63:0] typ_pl, typ_ph;
    logic [19:0] rp, rt;
    sb = new();
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b0;
    in_ch.valid = 1'b0; in_ch.raw_pressure = '0; in_ch.raw_temperature = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers at reset: divisor is zero, pressure flagged invalid
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'd415148, 20'd519888);
    drain();

    // Typical calibration: directed extremes of the raw readings
    typ_t  = {16'hFC18, 16'd26435, 16'd27504};
    typ_ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    typ_pl = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    load_cal(typ_t, typ_pl, typ_ph, 16'd6000);
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'd0, 20'hFFFFF);
    send_item(20'hFFFFF, 20'd0);
    send_item(20'd415148, 20'd519888);
    send_item(20'h80000, 20'h80000);
    send_item(20'h7FFFF, 20'h7FFFF);
    send_item(20'd300000, 20'd400000);
    send_item(20'd600000, 20'd650000);
    drain();

    // Random phases over several calibration settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_cal(typ_t, typ_pl, typ_ph, 16'd6000);
        1: load_cal('1, '1, '1, '1);
        2: load_cal({16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
        3: load_cal({16'h7FFF, 16'h8000, 16'h0000},
                    {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
                    {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h7FFF);
        default: begin
          if (ph % 2 == 0)
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
          else
            load_cal(typ_t ^ 48'({$urandom_range(255), $urandom_range(255)}),
                     typ_pl ^ {$urandom_range(255), $urandom_range(255)},
                     typ_ph ^ {$urandom_range(255), $urandom_range(255)},
                     16'(16'd6000 ^ $urandom_range(255)));
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 168; k++) begin
        if (k % 8 == 3 && ph == 4 && k < 40) begin
          send_idle_pct = 0;
        end
        if ($urandom_range(99) < 70) begin
          rp = 20'(20'd415148 + $urandom_range(200000) - 20'd100000);
          rt = 20'(20'd519888 + $urandom_range(200000) - 20'd100000);
        end else begin
          rp = 20'($urandom);
          rt = 20'($urandom);
        end
        send_item(rp, rt);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
